// ===== design/rcb_pkg.sv =====
// ----------------------------------------------------------------------------
// RGBA colour blend package
// Factor, equation and register codes, the per-channel configuration type
// and the exact unorm8 product shared by the blend channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rcb_pkg;

  localparam int unsigned ChanW = 8;
  localparam logic [ChanW-1:0] UnormOne = 8'hFF;

  // Blend factor codes.
  localparam logic [3:0] FCT_ONE          = 4'd0;
  localparam logic [3:0] FCT_SRC_COLOR    = 4'd1;
  localparam logic [3:0] FCT_SRC_ALPHA    = 4'd2;
  localparam logic [3:0] FCT_DST_ALPHA    = 4'd3;
  localparam logic [3:0] FCT_DST_COLOR    = 4'd4;
  localparam logic [3:0] FCT_ALPHA_SAT    = 4'd5;
  localparam logic [3:0] FCT_CONST_COLOR  = 4'd6;
  localparam logic [3:0] FCT_CONST_ALPHA  = 4'd7;
  localparam logic [3:0] FCT_ZERO         = 4'd8;
  localparam logic [3:0] FCT_INV_SRC_COL  = 4'd9;
  localparam logic [3:0] FCT_INV_SRC_ALP  = 4'd10;
  localparam logic [3:0] FCT_INV_DST_ALP  = 4'd11;
  localparam logic [3:0] FCT_INV_DST_COL  = 4'd12;
  localparam logic [3:0] FCT_INV_CON_COL  = 4'd13;
  localparam logic [3:0] FCT_INV_CON_ALP  = 4'd14;
  localparam logic [3:0] FCT_ONE_ALT      = 4'd15;

  // Blend equation codes.
  localparam logic [2:0] EQ_ADD     = 3'd0;
  localparam logic [2:0] EQ_SUB     = 3'd1;
  localparam logic [2:0] EQ_REV_SUB = 3'd2;
  localparam logic [2:0] EQ_MIN     = 3'd3;
  localparam logic [2:0] EQ_MAX     = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_BLEND_ENABLE   = 3'd0;
  localparam logic [2:0] REG_RGB_SRC_FCT    = 3'd1;
  localparam logic [2:0] REG_RGB_DST_FCT    = 3'd2;
  localparam logic [2:0] REG_ALP_SRC_FCT    = 3'd3;
  localparam logic [2:0] REG_ALP_DST_FCT    = 3'd4;
  localparam logic [2:0] REG_RGB_EQUATION   = 3'd5;
  localparam logic [2:0] REG_ALP_EQUATION   = 3'd6;
  localparam logic [2:0] REG_BLEND_CONSTANT = 3'd7;

  // Settings that steer one channel.
  typedef struct packed {
    logic [3:0] src_fct;
    logic [3:0] dst_fct;
    logic [2:0] equation;
  } rcb_chan_cfg_t;

  // Exact x*f/255 rounded to nearest: with t = x*f + 128, the quotient is
  // (t + (t >> 8)) >> 8 for every pair of unorm8 operands.
  function automatic logic [ChanW-1:0] unorm_mul(input logic [ChanW-1:0] x,
                                                 input logic [ChanW-1:0] f);
    logic [15:0] prod;
    logic [16:0] t;
    logic [16:0] s;
    prod = x * f;
    t    = {1'b0, prod} + 17'd128;
    s    = t + {8'd0, t[16:8]};
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== design/rcb_channel.sv =====
// ----------------------------------------------------------------------------
// RGBA colour blend channel
// Picks the source and destination factors of one channel, forms both
// rounded products and combines them with the channel's equation.
// ----------------------------------------------------------------------------
`default_nettype none

module rcb_channel (
  input  wire rcb_pkg::rcb_chan_cfg_t cfg,
  input  wire                         is_alpha,
  input  wire logic [7:0]             src,
  input  wire logic [7:0]             dst,
  input  wire logic [7:0]             con,
  input  wire logic [7:0]             src_alpha,
  input  wire logic [7:0]             dst_alpha,
  input  wire logic [7:0]             con_alpha,
  output logic      [7:0]             result
);
  import rcb_pkg::*;

  logic [7:0] sat_factor;
  logic [7:0] fs;
  logic [7:0] fd;
  logic [7:0] prod_s;
  logic [7:0] prod_d;
  logic [8:0] sum;

  // Alpha-saturate: min(As, 1 - Ad) on colour, one on alpha.
  always_comb begin
    if (is_alpha) begin
      sat_factor = UnormOne;
    end else if (src_alpha < (UnormOne - dst_alpha)) begin
      sat_factor = src_alpha;
    end else begin
      sat_factor = UnormOne - dst_alpha;
    end
  end

  // Factor selection for one code.
  function automatic logic [7:0] pick(input logic [3:0] code,
                                      input logic [7:0] s,
                                      input logic [7:0] d,
                                      input logic [7:0] k,
                                      input logic [7:0] sa,
                                      input logic [7:0] da,
                                      input logic [7:0] ka,
                                      input logic [7:0] sat);
    logic [7:0] f;
    case (code) inside
      FCT_SRC_COLOR:   f = s;
      FCT_SRC_ALPHA:   f = sa;
      FCT_DST_ALPHA:   f = da;
      FCT_DST_COLOR:   f = d;
      FCT_ALPHA_SAT:   f = sat;
      FCT_CONST_COLOR: f = k;
      FCT_CONST_ALPHA: f = ka;
      FCT_ZERO:        f = 8'd0;
      FCT_INV_SRC_COL: f = UnormOne - s;
      FCT_INV_SRC_ALP: f = UnormOne - sa;
      FCT_INV_DST_ALP: f = UnormOne - da;
      FCT_INV_DST_COL: f = UnormOne - d;
      FCT_INV_CON_COL: f = UnormOne - k;
      FCT_INV_CON_ALP: f = UnormOne - ka;
      FCT_ONE, FCT_ONE_ALT: f = UnormOne;
      default:         f = UnormOne;
    endcase
    return f;
  endfunction

  assign fs = pick(cfg.src_fct, src, dst, con, src_alpha, dst_alpha, con_alpha,
                   sat_factor);
  assign fd = pick(cfg.dst_fct, src, dst, con, src_alpha, dst_alpha, con_alpha,
                   sat_factor);

  // Rounded products of each side with its factor.
  assign prod_s = unorm_mul(src, fs);
  assign prod_d = unorm_mul(dst, fd);
  assign sum    = {1'b0, prod_s} + {1'b0, prod_d};

  // Combine the two products, saturating to the unorm range.
  always_comb begin
    case (cfg.equation)
      EQ_ADD:     result = sum[8] ? UnormOne : sum[7:0];
      EQ_SUB:     result = (prod_s > prod_d) ? (prod_s - prod_d) : 8'd0;
      EQ_REV_SUB: result = (prod_d > prod_s) ? (prod_d - prod_s) : 8'd0;
      EQ_MIN:     result = (prod_s < prod_d) ? prod_s : prod_d;
      EQ_MAX:     result = (prod_s > prod_d) ? prod_s : prod_d;
      default:    result = prod_s;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rgba_color_blend_unit_core.sv =====
// ----------------------------------------------------------------------------
// RGBA colour blend unit
// Blends a source RGBA8 pixel with a destination RGBA8 pixel using
// programmable factors and equations for colour and for alpha.
// ----------------------------------------------------------------------------
// Usage:
//   An item (one source and one destination pixel) is taken at a rising edge
//   where start is high and busy is low. Each item gives exactly one result,
//   shown on out_red .. out_alpha for one cycle with out_valid high.
//   The item is captured in the input register, the blend logic works on
//   it combinationally and the result register drives the outputs. A new
//   item may be started every cycle while busy is low, so throughput is
//   one item per clock; the single blend pass between the input and
//   result registers sets that figure.
//   The receiver cannot stall, so results are never held back.
//   Configuration is written through cfg_we, cfg_index and cfg_wdata with no
//   wait; it should only change while no item is in flight.
//   Synchronous reset (rst_n low) restores the register defaults (blending
//   off, source one, destination zero, add), drops any item in flight and
//   holds busy high until reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_color_blend_unit_core (
  input  wire        clk,
  input  wire        rst_n,
  // Item input.
  input  wire        start,
  output logic       busy,
  input  wire  [7:0] in_src_red,
  input  wire  [7:0] in_src_green,
  input  wire  [7:0] in_src_blue,
  input  wire  [7:0] in_src_alpha,
  input  wire  [7:0] in_dst_red,
  input  wire  [7:0] in_dst_green,
  input  wire  [7:0] in_dst_blue,
  input  wire  [7:0] in_dst_alpha,
  // Result output.
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  // Configuration write port.
  input  wire        cfg_we,
  input  wire  [2:0] cfg_index,
  input  wire [31:0] cfg_wdata
);
  import rcb_pkg::*;

  logic        busy_r;
  logic        in_valid_r;
  logic [7:0]  src_r [4];
  logic [7:0]  dst_r [4];
  logic        out_valid_r;
  logic [7:0]  res_r [4];
  logic [7:0]  res_nxt [4];
  logic [7:0]  blend [4];
  logic [7:0]  con [4];

  logic          blend_en_r;
  rcb_chan_cfg_t rgb_cfg_r;
  rcb_chan_cfg_t alp_cfg_r;
  logic [31:0]   const_r;

  logic accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Busy only while reset holds the unit.
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_en_r         <= 1'b0;
      rgb_cfg_r.src_fct  <= FCT_ONE;
      rgb_cfg_r.dst_fct  <= FCT_ZERO;
      alp_cfg_r.src_fct  <= FCT_ONE;
      alp_cfg_r.dst_fct  <= FCT_ZERO;
      rgb_cfg_r.equation <= EQ_ADD;
      alp_cfg_r.equation <= EQ_ADD;
      const_r            <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_ENABLE:   blend_en_r         <= cfg_wdata[0];
        REG_RGB_SRC_FCT:    rgb_cfg_r.src_fct  <= cfg_wdata[3:0];
        REG_RGB_DST_FCT:    rgb_cfg_r.dst_fct  <= cfg_wdata[3:0];
        REG_ALP_SRC_FCT:    alp_cfg_r.src_fct  <= cfg_wdata[3:0];
        REG_ALP_DST_FCT:    alp_cfg_r.dst_fct  <= cfg_wdata[3:0];
        REG_RGB_EQUATION:   rgb_cfg_r.equation <= cfg_wdata[2:0];
        REG_ALP_EQUATION:   alp_cfg_r.equation <= cfg_wdata[2:0];
        REG_BLEND_CONSTANT: const_r            <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: control with reset, payload without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r[0] <= in_src_red;
      src_r[1] <= in_src_green;
      src_r[2] <= in_src_blue;
      src_r[3] <= in_src_alpha;
      dst_r[0] <= in_dst_red;
      dst_r[1] <= in_dst_green;
      dst_r[2] <= in_dst_blue;
      dst_r[3] <= in_dst_alpha;
    end
  end

  // Constant colour split into channels.
  assign con[0] = const_r[7:0];
  assign con[1] = const_r[15:8];
  assign con[2] = const_r[23:16];
  assign con[3] = const_r[31:24];

  // One blend lane per channel; the last lane is alpha.
  for (genvar ch = 0; ch < 4; ch++) begin : g_lane
    rcb_channel u_chan (
      .cfg       ((ch == 3) ? alp_cfg_r : rgb_cfg_r),
      .is_alpha  ((ch == 3) ? 1'b1 : 1'b0),
      .src       (src_r[ch]),
      .dst       (dst_r[ch]),
      .con       (con[ch]),
      .src_alpha (src_r[3]),
      .dst_alpha (dst_r[3]),
      .con_alpha (con[3]),
      .result    (blend[ch])
    );

    assign res_nxt[ch] = blend_en_r ? blend[ch] : src_r[ch];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = res_r[0];
  assign out_green = res_r[1];
  assign out_blue  = res_r[2];
  assign out_alpha = res_r[3];

`ifndef SYNTH
  // Every accepted item reaches the result register by way of the input register.
  a_item_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("accepted item produced no result");

  // No result appears without an item in the input register before it.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_valid_r))
    else $error("result without a captured item");

  // The unit never reports busy once reset is released.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy_r)
    else $error("busy raised outside reset");
`endif

endmodule

`default_nettype wire
